[src/ffsa_pkg.sv]
// ffsa_pkg: shared types and constants for the first-fit segment allocator
// no dependencies
package ffsa_pkg;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_BADSIZE = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NONAME  = 3'd4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic init;        // reset table to one free segment
    logic load_req;    // capture request
    logic scan_clr;    // restart scan pointer
    logic scan_step;   // examine entry at pointer and advance
    logic shift_up;    // move entry ptr-1 into ptr, decrement ptr
    logic split_fix;   // write split pair at hit index
    logic mark_free;   // clear busy at hit
    logic merge_next;  // add hit+1 length into hit, start removal at hit+1
    logic merge_prev;  // add hit length into hit-1, start removal at hit
    logic shift_down;  // move entry ptr+1 into ptr, increment ptr
    logic dec_count;   // drop one entry
    logic set_result;  // latch result
  } ffsa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic req_free;
    logic bad_size;
    logic bad_name;
    logic scan_done;   // pointer reached count
    logic hit;         // a match has been latched
    logic need_split;
    logic table_full;
    logic shift_up_done;
    logic has_next_free;
    logic has_prev_free;
    logic shift_down_done;
  } ffsa_sts_t;

endpackage

[src/ffsa_if.sv]
// ffsa_if: valid/ready channel carrying a generic payload
// depends on nothing
interface ffsa_if #(parameter int W = 1) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/ffsa_datapath.sv]
// ffsa_datapath: segment table, scan pointer and request/result registers
// depends on ffsa_pkg
module ffsa_datapath import ffsa_pkg::*; #(
  parameter int MAX_SEGMENTS = 32,
  parameter int NAME_COUNT   = 26
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ffsa_cmd_t   cmd,
  output ffsa_sts_t   sts,
  input  logic [15:0] mem_size,
  input  logic        in_kind,
  input  logic [15:0] in_size,
  input  logic [4:0]  in_name,
  output logic [2:0]  res_status,
  output logic [15:0] res_address,
  output logic [4:0]  res_owner,
  input  logic [2:0]  fail_status,
  input  logic        fail
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  logic            busy_r  [MAX_SEGMENTS];
  logic [4:0]      owner_r [MAX_SEGMENTS];
  logic [15:0]     start_r [MAX_SEGMENTS];
  logic [16:0]     len_r   [MAX_SEGMENTS];

  logic [CW-1:0] count_r;
  logic [CW-1:0] ptr_r;
  logic [IW-1:0] hit_r;
  logic          hit_valid_r;
  logic [4:0]    next_owner_r;
  logic          kind_r;
  logic [15:0]   size_r;
  logic [4:0]    name_r;

  logic [IW-1:0] p;
  logic [IW-1:0] hp1;
  logic [IW-1:0] hm1;
  logic          match;

  assign p   = ptr_r[IW-1:0];
  assign hp1 = hit_r + IW'(1);
  assign hm1 = hit_r - IW'(1);
  assign match = (kind_r == KIND_ALLOC)
    ? (!busy_r[p] && len_r[p] >= {1'b0, size_r})
    : (busy_r[p] && owner_r[p] == name_r);

  always_comb begin
    sts = '0;
    sts.req_free        = kind_r;
    sts.bad_size        = (size_r == 16'd0) || (size_r > mem_size);
    sts.bad_name        = {27'd0, name_r} >= NAME_COUNT;
    sts.scan_done       = ptr_r >= count_r;
    sts.hit             = hit_valid_r;
    sts.need_split      = len_r[hit_r] > {1'b0, size_r};
    sts.table_full      = count_r >= CW'(MAX_SEGMENTS);
    sts.shift_up_done   = ptr_r <= {{(CW-IW){1'b0}}, hp1} || hit_r == IW'(MAX_SEGMENTS - 1);
    sts.has_next_free   = ({{(CW-IW){1'b0}}, hit_r} + CW'(1) < count_r) && !busy_r[hp1];
    sts.has_prev_free   = (hit_r != '0) && !busy_r[hm1];
    sts.shift_down_done = ptr_r + CW'(1) >= count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= CW'(1);
      next_owner_r <= '0;
      hit_valid_r  <= 1'b0;
      ptr_r        <= '0;
      busy_r[0]    <= 1'b0;
      start_r[0]   <= '0;
      len_r[0]     <= 17'd512;
      owner_r[0]   <= '0;
    end else begin
      if (cmd.init) begin
        count_r      <= CW'(1);
        next_owner_r <= '0;
        busy_r[0]    <= 1'b0;
        owner_r[0]   <= '0;
        start_r[0]   <= '0;
        len_r[0]     <= {1'b0, mem_size};
      end
      if (cmd.load_req) begin
        kind_r <= in_kind;
        size_r <= in_size;
        name_r <= in_name;
      end
      if (cmd.scan_clr) begin
        ptr_r       <= '0;
        hit_valid_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (match) begin
          hit_r       <= p;
          hit_valid_r <= 1'b1;
          ptr_r       <= count_r;
        end else begin
          ptr_r <= ptr_r + CW'(1);
        end
      end
      if (cmd.shift_up) begin
        busy_r[p]  <= busy_r[p - IW'(1)];
        owner_r[p] <= owner_r[p - IW'(1)];
        start_r[p] <= start_r[p - IW'(1)];
        len_r[p]   <= len_r[p - IW'(1)];
        ptr_r      <= ptr_r - CW'(1);
      end
      if (cmd.split_fix) begin
        busy_r[hp1]  <= 1'b0;
        owner_r[hp1] <= '0;
        start_r[hp1] <= start_r[hit_r] + size_r;
        len_r[hp1]   <= len_r[hit_r] - {1'b0, size_r};
        len_r[hit_r] <= {1'b0, size_r};
        count_r      <= count_r + CW'(1);
      end
      if (cmd.set_result) begin
        if (fail) begin
          res_status  <= fail_status;
          res_address <= '0;
          res_owner   <= 5'(NAME_COUNT);
        end else if (kind_r == KIND_ALLOC) begin
          busy_r[hit_r] <= 1'b1;
          res_status    <= ST_OK;
          res_address   <= start_r[hit_r];
          if ({27'd0, next_owner_r} < NAME_COUNT) begin
            owner_r[hit_r] <= next_owner_r;
            res_owner      <= next_owner_r;
            next_owner_r   <= next_owner_r + 5'd1;
          end else begin
            owner_r[hit_r] <= 5'(NAME_COUNT);
            res_owner      <= 5'(NAME_COUNT);
          end
        end else begin
          res_status  <= ST_OK;
          res_address <= '0;
          res_owner   <= 5'(NAME_COUNT);
        end
      end
      if (cmd.mark_free) begin
        busy_r[hit_r]  <= 1'b0;
        owner_r[hit_r] <= '0;
      end
      if (cmd.merge_next) begin
        len_r[hit_r] <= len_r[hit_r] + len_r[hp1];
        ptr_r        <= {{(CW-IW){1'b0}}, hp1};
      end
      if (cmd.merge_prev) begin
        len_r[hm1] <= len_r[hm1] + len_r[hit_r];
        ptr_r      <= {{(CW-IW){1'b0}}, hit_r};
      end
      if (cmd.shift_down) begin
        if (ptr_r + CW'(1) < count_r) begin
          busy_r[p]  <= busy_r[p + IW'(1)];
          owner_r[p] <= owner_r[p + IW'(1)];
          start_r[p] <= start_r[p + IW'(1)];
          len_r[p]   <= len_r[p + IW'(1)];
        end
        ptr_r <= ptr_r + CW'(1);
      end
      if (cmd.dec_count) begin
        count_r <= count_r - CW'(1);
      end
    end
  end
endmodule

[src/ffsa_ctrl.sv]
// ffsa_ctrl: request sequencer for the allocator
// depends on ffsa_pkg
module ffsa_ctrl import ffsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ffsa_sts_t  sts,
  output ffsa_cmd_t  cmd,
  output logic [2:0] fail_status,
  output logic       fail
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_SHUP   = 4'd4;
  localparam logic [3:0] S_SPLIT  = 4'd5;
  localparam logic [3:0] S_FIN    = 4'd6;
  localparam logic [3:0] S_MNEXT  = 4'd7;
  localparam logic [3:0] S_SHD1   = 4'd8;
  localparam logic [3:0] S_MPREV  = 4'd9;
  localparam logic [3:0] S_SHD2   = 4'd10;
  localparam logic [3:0] S_FAIL   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [2:0] fst_r, fst_nxt;
  logic       ov_r, ov_nxt;

  assign in_ready    = (state_r == S_IDLE) && !ov_r;
  assign out_valid   = ov_r;
  assign fail_status = fst_r;
  assign fail        = (state_r == S_FAIL);

  always_comb begin
    state_nxt = state_r;
    fst_nxt   = fst_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    cmd.init  = cfg_we;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_req = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.req_free && sts.bad_size) begin
          fst_nxt = ST_BADSIZE; state_nxt = S_FAIL;
        end else if (sts.req_free && sts.bad_name) begin
          fst_nxt = ST_NONAME; state_nxt = S_FAIL;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DECIDE: begin
        if (!sts.hit) begin
          fst_nxt   = sts.req_free ? ST_NONAME : ST_NOFIT;
          state_nxt = S_FAIL;
        end else if (sts.req_free) begin
          cmd.mark_free = 1'b1;
          state_nxt     = S_MNEXT;
        end else if (sts.need_split) begin
          if (sts.table_full) begin
            fst_nxt = ST_FULL; state_nxt = S_FAIL;
          end else begin
            state_nxt = S_SHUP;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SHUP: begin
        if (sts.shift_up_done) begin
          state_nxt = S_SPLIT;
        end else begin
          cmd.shift_up = 1'b1;
        end
      end
      S_SPLIT: begin
        cmd.split_fix = 1'b1;
        state_nxt     = S_FIN;
      end
      S_MNEXT: begin
        if (sts.has_next_free) begin
          cmd.merge_next = 1'b1;
          state_nxt      = S_SHD1;
        end else begin
          state_nxt = S_MPREV;
        end
      end
      S_SHD1: begin
        cmd.shift_down = 1'b1;
        if (sts.shift_down_done) begin
          cmd.dec_count = 1'b1;
          state_nxt     = S_MPREV;
        end
      end
      S_MPREV: begin
        if (sts.has_prev_free) begin
          cmd.merge_prev = 1'b1;
          state_nxt      = S_SHD2;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SHD2: begin
        cmd.shift_down = 1'b1;
        if (sts.shift_down_done) begin
          cmd.dec_count = 1'b1;
          state_nxt     = S_FIN;
        end
      end
      S_FIN, S_FAIL: begin
        cmd.set_result = 1'b1;
        ov_nxt         = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fst_r   <= ST_OK;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fst_r   <= fst_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

[src/first_fit_segment_allocator.sv]
// first_fit_segment_allocator: top level of the first-fit segment allocator
// depends on ffsa_pkg, ffsa_if, ffsa_ctrl, ffsa_datapath
//
// usage
// - in channel: a transaction carries kind (0 allocate, 1 free), alloc_size
//   and free_name; one request is worked on at a time
// - out channel: one transaction per request with status, address and owner
// - flow: the request is checked, then the table is scanned entry by entry;
//   a split opens a slot and a merge closes one by moving entries singly, so
//   the worst case is set by the single-entry scan and shift loops
// - a new request is taken only once the previous result has been taken;
//   a stalled receiver holds the result register and the block waits
// - reset: one free segment of 512 bytes at address 0, names restart at A
// - cfg: writing the heap size rebuilds the table as one free segment and
//   restarts names; write only while idle
module first_fit_segment_allocator import ffsa_pkg::*; #(
  parameter int MAX_SEGMENTS = 32,
  parameter int NAME_COUNT   = 26
) (
  input logic        clk,
  input logic        rst_n,
  ffsa_if.sink       in_ch,
  ffsa_if.source     out_ch,
  input logic        cfg_we,
  input logic [15:0] cfg_wdata
);
  ffsa_cmd_t   cmd;
  ffsa_sts_t   sts;
  logic [15:0] mem_size_r;
  logic [15:0] dp_size;
  logic [2:0]  fail_status;
  logic        fail;
  logic [2:0]  res_status;
  logic [15:0] res_address;
  logic [4:0]  res_owner;

  // heap size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r <= 16'd512;
    end else if (cfg_we) begin
      mem_size_r <= cfg_wdata;
    end
  end

  // on a write the new size goes straight into the rebuilt table
  assign dp_size = cfg_we ? cfg_wdata : mem_size_r;

  ffsa_ctrl u_ctrl (
    .clk, .rst_n, .cfg_we,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready),
    .sts, .cmd, .fail_status, .fail
  );

  // payload order: kind, alloc_size, free_name
  ffsa_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .NAME_COUNT(NAME_COUNT)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .mem_size (dp_size),
    .in_kind (in_ch.data[21]), .in_size (in_ch.data[20:5]), .in_name (in_ch.data[4:0]),
    .res_status, .res_address, .res_owner, .fail_status, .fail
  );

  // result payload order: status, address, owner
  assign out_ch.data = {res_status, res_address, res_owner};
endmodule
